// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CBTM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication, disabled while reset is asserted
`define CBTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ----- sv/cbtm_pkg.sv -----
// shared types and constants of the convective boundary triangle matrix block
// widths of every datapath stage, quadrature weights, rounding divider constants
`default_nettype none

package cbtm_pkg;

	// field widths
	localparam int H_W   = 31;            // coefficient and area
	localparam int T_W   = 32;            // temperature
	localparam int D_W   = T_W + 1;       // temperature minus ambient
	localparam int Q_W   = 32;            // capped quotient out of the divider

	// datapath widths
	localparam int W_W   = 38;            // matrix weight scaled by 648
	localparam int WL_W  = 19;            // low slice of a weight
	localparam int WH_W  = W_W - WL_W;    // high slice of a weight
	localparam int PE_W  = H_W + WL_W;    // area times weight slice
	localparam int PL_W  = WL_W + 1 + D_W; // weight slice times signed difference
	localparam int E_W   = 74;            // signed weighted sum of differences
	localparam int MAG_W = 72;            // its magnitude
	localparam int CH_W  = 24;            // magnitude slice fed to a multiplier
	localparam int PM_W  = H_W + CH_W;    // area times magnitude slice
	localparam int NE_W  = H_W + W_W;     // matrix numerator
	localparam int NL_W  = H_W + MAG_W;   // load numerator

	// pipeline depth, input register through output register
	localparam int STAGES = 10;

	// quadrature weights over a common denominator of 648
	localparam logic [6:0] W_OWN  = 7'd66;
	localparam logic [6:0] W_NEAR = 7'd21;
	localparam logic [6:0] W_FAR  = 7'd12;

	// 648 = 8 * 81: power of two is a shift, 81 goes through a reciprocal
	localparam int QDIV        = 81;
	localparam int QROUND_HALF = 324;
	localparam int DIV_SHIFT   = 3;
	localparam int RECIP_SHIFT = 46;
	localparam int X_W         = 39;
	localparam int RP_W        = 20;
	localparam logic [63:0] RECIP = ((64'd1 << RECIP_SHIFT) + 64'(QDIV - 1)) / 64'(QDIV);
	localparam logic [RP_W-1:0] RECIP_LO = RECIP[RP_W-1:0];
	localparam logic [RP_W-1:0] RECIP_HI = RECIP[2*RP_W-1:RP_W];
	localparam logic [X_W-1:0] X_LIMIT = X_W'(QDIV) << Q_W;

	// saturation values
	localparam logic [Q_W-1:0] Q_CAP     = 32'h8000_0000;
	localparam logic [H_W-1:0] ENTRY_MAX = 31'h7FFF_FFFF;
	localparam logic [Q_W-1:0] LOAD_MAX  = 32'h7FFF_FFFF;

	typedef logic [STAGES-1:0] stage_vec_t;

	typedef struct packed {
		logic        [H_W-1:0] coeff_node_a;
		logic        [H_W-1:0] coeff_node_b;
		logic        [H_W-1:0] coeff_node_c;
		logic signed [T_W-1:0] temp_node_a;
		logic signed [T_W-1:0] temp_node_b;
		logic signed [T_W-1:0] temp_node_c;
		logic        [H_W-1:0] face_area;
	} element_t;

	typedef struct packed {
		logic        [H_W-1:0] entry_aa;
		logic        [H_W-1:0] entry_ab;
		logic        [H_W-1:0] entry_ac;
		logic        [H_W-1:0] entry_bb;
		logic        [H_W-1:0] entry_bc;
		logic        [H_W-1:0] entry_cc;
		logic signed [T_W-1:0] load_a;
		logic signed [T_W-1:0] load_b;
		logic signed [T_W-1:0] load_c;
	} result_t;

endpackage

`default_nettype wire

// ----- sv/cbtm_stream_if.sv -----
// valid/ready stream channel carrying one payload word per handshake
// payload type is set per instance; used with element_t and result_t of cbtm_pkg
`default_nettype none

interface cbtm_stream_if #(parameter type data_t = logic) ();
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/convective_boundary_triangle_matrix.sv -----
// Convective boundary matrix of a linear triangle face. Each element word
// (three nodal coefficients, three nodal temperatures, face area) gives the six
// distinct entries of the symmetric 3x3 convection matrix and the three nodal
// loads, all Q(FRAC_BITS) fixed point, rounded to nearest with ties away from
// zero and saturated. One element is taken every clock unless a result stall
// reaches the input. Three node lanes run in parallel, each a 9-stage multiply
// and divide pipeline, and a final register merges their outputs. A stall on
// the result side holds only stages that are full, so empty stages keep
// accepting. The ambient temperature register is written via cfg_we/cfg_data;
// the user must write it only while the block is idle; the block does not
// enforce it. Depends on cbtm_pkg, cbtm_stream_if, cbtm_lane and cbtm_rdiv.
`default_nettype none

module convective_boundary_triangle_matrix import cbtm_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic signed [T_W-1:0] cfg_data,
	cbtm_stream_if.sink                element,
	cbtm_stream_if.source              result
);

	logic signed [T_W-1:0] amb_q;
	stage_vec_t            v_q;
	stage_vec_t            en;
	logic        [H_W-1:0] h_in [3];
	logic signed [D_W-1:0] d_in [3];
	logic        [Q_W-1:0] diag_qs [3];
	logic        [Q_W-1:0] off_qs [3];
	logic        [Q_W-1:0] load_qs [3];
	logic                  load_pos [3];
	logic        [H_W-1:0] diag_e [3];
	logic        [H_W-1:0] off_e [3];
	logic        [Q_W-1:0] load_v [3];
	result_t               out_d;
	result_t               out_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amb_q <= '0;
		end else if (cfg_we) begin
			amb_q <= cfg_data;
		end
	end

	// a stage moves when it is empty or the one after it moves
	always_comb begin
		en[STAGES-1] = !v_q[STAGES-1] || result.ready;
		for (int k = STAGES - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= element.valid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign element.ready = en[0];

	always_comb begin
		h_in[0] = element.data.coeff_node_a;
		h_in[1] = element.data.coeff_node_b;
		h_in[2] = element.data.coeff_node_c;
		d_in[0] = D_W'(element.data.temp_node_a) - D_W'(amb_q);
		d_in[1] = D_W'(element.data.temp_node_b) - D_W'(amb_q);
		d_in[2] = D_W'(element.data.temp_node_c) - D_W'(amb_q);
	end

	// lane g owns node g; its off-diagonal entry pairs it with node g+1
	for (genvar g = 0; g < 3; g++) begin : g_lane
		cbtm_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk      (clk),
			.en       (en),
			.h_own    (h_in[g]),
			.h_next   (h_in[(g+1)%3]),
			.h_prev   (h_in[(g+2)%3]),
			.d_own    (d_in[g]),
			.d_next   (d_in[(g+1)%3]),
			.d_prev   (d_in[(g+2)%3]),
			.area     (element.data.face_area),
			.diag_qs  (diag_qs[g]),
			.off_qs   (off_qs[g]),
			.load_qs  (load_qs[g]),
			.load_pos (load_pos[g])
		);
	end

	// merge: saturate entries, apply load sign
	always_comb begin
		for (int g = 0; g < 3; g++) begin
			diag_e[g] = diag_qs[g][Q_W-1] ? ENTRY_MAX : diag_qs[g][H_W-1:0];
			off_e[g]  = off_qs[g][Q_W-1] ? ENTRY_MAX : off_qs[g][H_W-1:0];
			if (load_pos[g]) begin
				load_v[g] = load_qs[g][Q_W-1] ? LOAD_MAX : load_qs[g];
			end else begin
				load_v[g] = -load_qs[g];
			end
		end
		out_d.entry_aa = diag_e[0];
		out_d.entry_ab = off_e[0];
		out_d.entry_bb = diag_e[1];
		out_d.entry_bc = off_e[1];
		out_d.entry_cc = diag_e[2];
		out_d.entry_ac = off_e[2];
		out_d.load_a   = $signed(load_v[0]);
		out_d.load_b   = $signed(load_v[1]);
		out_d.load_c   = $signed(load_v[2]);
	end

	always_ff @(posedge clk) begin
		if (en[STAGES-1]) begin
			out_s10 <= out_d;
		end
	end

	assign result.valid = v_q[STAGES-1];
	assign result.data  = out_s10;

endmodule

`default_nettype wire

// ----- sv/cbtm_rdiv.sv -----
// rounded divide by 648 << SHIFT with saturation, three pipeline stages
// uses cbtm_pkg constants; quotient by 81 is a split reciprocal multiply
`default_nettype none

module cbtm_rdiv import cbtm_pkg::*; #(
	parameter int IN_W  = 69,
	parameter int SHIFT = 16
) (
	input  wire logic             clk,
	input  wire logic [2:0]       en,
	input  wire logic [IN_W-1:0]  n,
	output logic      [Q_W-1:0]   qs
);

	localparam int XF_W = IN_W - SHIFT - 2;
	localparam logic [IN_W:0] RND = (IN_W + 1)'(QROUND_HALF) << SHIFT;

	logic [IN_W:0]         sum;
	logic [XF_W-1:0]       x_full;
	logic [X_W-1:0]        x_s1;
	logic                  ovf_s1;
	logic [X_W+RP_W-1:0]   p_lo_s2;
	logic [X_W+RP_W-1:0]   p_hi_s2;
	logic                  ovf_s2;
	logic [X_W+2*RP_W-1:0] prod;
	logic [Q_W-1:0]        q;

	// adding half the divisor turns the floor into round half up
	always_comb begin
		sum    = {1'b0, n} + RND;
		x_full = sum[IN_W:SHIFT+DIV_SHIFT];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s1   <= x_full[X_W-1:0];
			ovf_s1 <= (|x_full[XF_W-1:X_W]) || (x_full[X_W-1:0] >= X_LIMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			p_lo_s2 <= (X_W+RP_W)'(x_s1) * (X_W+RP_W)'(RECIP_LO);
			p_hi_s2 <= (X_W+RP_W)'(x_s1) * (X_W+RP_W)'(RECIP_HI);
			ovf_s2  <= ovf_s1;
		end
	end

	// below the limit the quotient stays under 2^32
	always_comb begin
		prod = {p_hi_s2, RP_W'(0)} + (X_W+2*RP_W)'(p_lo_s2);
		q    = prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			qs <= (ovf_s2 || q > Q_CAP) ? Q_CAP : q;
		end
	end

endmodule

`default_nettype wire

// ----- sv/cbtm_lane.sv -----
// one node lane: diagonal entry, entry toward the next node and the node load
// uses cbtm_pkg widths and weights, three cbtm_rdiv units at its tail
`default_nettype none

module cbtm_lane import cbtm_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                  clk,
	input  wire stage_vec_t            en,
	input  wire logic        [H_W-1:0] h_own,
	input  wire logic        [H_W-1:0] h_next,
	input  wire logic        [H_W-1:0] h_prev,
	input  wire logic signed [D_W-1:0] d_own,
	input  wire logic signed [D_W-1:0] d_next,
	input  wire logic signed [D_W-1:0] d_prev,
	input  wire logic        [H_W-1:0] area,
	output logic             [Q_W-1:0] diag_qs,
	output logic             [Q_W-1:0] off_qs,
	output logic             [Q_W-1:0] load_qs,
	output logic                       load_pos
);

	// index 0: own node, 1: next node, 2: previous node
	logic        [W_W-1:0]   w_in [3];
	logic        [W_W-1:0]   w_s1 [3];
	logic signed [D_W-1:0]   d_s1 [3];
	logic        [H_W-1:0]   area_s1, area_s2, area_s3, area_s4;
	logic        [PE_W-1:0]  ed_lo_s2, ed_hi_s2, eo_lo_s2, eo_hi_s2;
	logic signed [PL_W-1:0]  lp_lo_s2 [3];
	logic signed [PL_W-1:0]  lp_hi_s2 [3];
	logic signed [E_W-1:0]   e_sum;
	logic signed [E_W-1:0]   e_s3;
	logic signed [E_W-1:0]   e_abs;
	logic        [NE_W-1:0]  nd_s3, no_s3, nd_s4, no_s4, nd_s5, no_s5, nd_s6, no_s6;
	logic                    neg_s4, neg_s5, neg_s6, neg_s7, neg_s8, neg_s9;
	logic        [MAG_W-1:0] mag_s4;
	logic        [PM_W-1:0]  pm_s5 [3];
	logic        [NL_W-1:0]  nl_s6;

	always_comb begin
		w_in[0] = W_W'(h_own) * W_W'(W_OWN) + W_W'(h_next) * W_W'(W_NEAR)
			+ W_W'(h_prev) * W_W'(W_NEAR);
		w_in[1] = W_W'(h_own) * W_W'(W_NEAR) + W_W'(h_next) * W_W'(W_NEAR)
			+ W_W'(h_prev) * W_W'(W_FAR);
		w_in[2] = W_W'(h_own) * W_W'(W_NEAR) + W_W'(h_next) * W_W'(W_FAR)
			+ W_W'(h_prev) * W_W'(W_NEAR);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			w_s1    <= w_in;
			d_s1[0] <= d_own;
			d_s1[1] <= d_next;
			d_s1[2] <= d_prev;
			area_s1 <= area;
		end
	end

	// weights split in two slices to keep each multiplier narrow
	always_ff @(posedge clk) begin
		if (en[1]) begin
			ed_lo_s2 <= PE_W'(area_s1) * PE_W'(w_s1[0][WL_W-1:0]);
			ed_hi_s2 <= PE_W'(area_s1) * PE_W'(w_s1[0][W_W-1:WL_W]);
			eo_lo_s2 <= PE_W'(area_s1) * PE_W'(w_s1[1][WL_W-1:0]);
			eo_hi_s2 <= PE_W'(area_s1) * PE_W'(w_s1[1][W_W-1:WL_W]);
			for (int x = 0; x < 3; x++) begin
				lp_lo_s2[x] <= PL_W'($signed({1'b0, w_s1[x][WL_W-1:0]})) * PL_W'(d_s1[x]);
				lp_hi_s2[x] <= PL_W'($signed({1'b0, w_s1[x][W_W-1:WL_W]})) * PL_W'(d_s1[x]);
			end
			area_s2 <= area_s1;
		end
	end

	always_comb begin
		e_sum = '0;
		for (int x = 0; x < 3; x++) begin
			e_sum = e_sum + (E_W'(lp_hi_s2[x]) <<< WL_W) + E_W'(lp_lo_s2[x]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			e_s3    <= e_sum;
			nd_s3   <= (NE_W'(ed_hi_s2) << WL_W) + NE_W'(ed_lo_s2);
			no_s3   <= (NE_W'(eo_hi_s2) << WL_W) + NE_W'(eo_lo_s2);
			area_s3 <= area_s2;
		end
	end

	assign e_abs = e_s3[E_W-1] ? -e_s3 : e_s3;

	// a negative weighted difference gives a positive load
	always_ff @(posedge clk) begin
		if (en[3]) begin
			neg_s4  <= e_s3[E_W-1];
			mag_s4  <= e_abs[MAG_W-1:0];
			nd_s4   <= nd_s3;
			no_s4   <= no_s3;
			area_s4 <= area_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int c = 0; c < 3; c++) begin
				pm_s5[c] <= PM_W'(area_s4) * PM_W'(mag_s4[c*CH_W +: CH_W]);
			end
			neg_s5 <= neg_s4;
			nd_s5  <= nd_s4;
			no_s5  <= no_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			nl_s6  <= (NL_W'(pm_s5[2]) << (2*CH_W)) + (NL_W'(pm_s5[1]) << CH_W)
				+ NL_W'(pm_s5[0]);
			neg_s6 <= neg_s5;
			nd_s6  <= nd_s5;
			no_s6  <= no_s5;
		end
	end

	cbtm_rdiv #(.IN_W(NE_W), .SHIFT(FRAC_BITS)) u_div_diag (
		.clk (clk),
		.en  (en[8:6]),
		.n   (nd_s6),
		.qs  (diag_qs)
	);

	cbtm_rdiv #(.IN_W(NE_W), .SHIFT(FRAC_BITS)) u_div_off (
		.clk (clk),
		.en  (en[8:6]),
		.n   (no_s6),
		.qs  (off_qs)
	);

	cbtm_rdiv #(.IN_W(NL_W), .SHIFT(2*FRAC_BITS)) u_div_load (
		.clk (clk),
		.en  (en[8:6]),
		.n   (nl_s6),
		.qs  (load_qs)
	);

	always_ff @(posedge clk) begin
		if (en[6]) begin
			neg_s7 <= neg_s6;
		end
		if (en[7]) begin
			neg_s8 <= neg_s7;
		end
		if (en[8]) begin
			neg_s9 <= neg_s8;
		end
	end

	assign load_pos = neg_s9;

endmodule

`default_nettype wire

// ----- sv/cbtm_checker.sv -----
// port-level checks of the convective boundary triangle matrix block
// depends on cbtm_pkg and assert_macros.svh; bound to the top level below
`default_nettype none

`include "assert_macros.svh"

module cbtm_checker import cbtm_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    in_valid,
	input wire logic    in_ready,
	input wire logic    out_valid,
	input wire logic    out_ready,
	input wire result_t out_data
);

	localparam int CNT_W = $clog2(STAGES + 2);

	logic [CNT_W-1:0] count_q;
	logic             in_acc;
	logic             out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// words taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q + CNT_W'(in_acc) - CNT_W'(out_acc);
		end
	end

	`CBTM_ASSERT_IMPL(a_no_phantom, clk, arst_n, out_valid, count_q != '0)
	`CBTM_ASSERT_IMPL(a_bounded, clk, arst_n, 1'b1, count_q <= CNT_W'(STAGES))
	`CBTM_ASSERT_IMPL(a_ready_empty, clk, arst_n, count_q == '0, in_ready)
	`CBTM_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind convective_boundary_triangle_matrix cbtm_checker u_cbtm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (element.valid),
	.in_ready  (element.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking testbench for convective_boundary_triangle_matrix
// element words in, matrix and load words out, checked against an exact wide-integer predictor
// depends on cbtm_pkg, cbtm_stream_if and the block itself
`default_nettype none

module tb_top import cbtm_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam logic [127:0] QUAD_DEN = 128'd648;
	localparam logic [127:0] ENTRY_DIV = QUAD_DEN << FRAC;
	localparam logic [127:0] LOAD_DIV = QUAD_DEN << (2 * FRAC);
	localparam int ONE = 32'h0001_0000;
	localparam int QUIET_LIMIT = 1000;
	localparam int DRAIN_CYCLES = STAGES + 20;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic signed [T_W-1:0] cfg_data;

	cbtm_stream_if #(.data_t(element_t)) elem_ch ();
	cbtm_stream_if #(.data_t(result_t)) result_ch ();

	convective_boundary_triangle_matrix #(
		.FRAC_BITS(FRAC)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.element(elem_ch),
		.result(result_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	element_t pending_elements[$];
	result_t awaited_results[$];
	logic signed [T_W-1:0] ambient;
	int fail_count;
	int gap_left;
	int stall_left;
	int quiet_cycles;
	bit src_burst;
	bit snk_burst;

	// n / d to nearest, ties away from zero, for n >= 0
	function automatic logic [127:0] div_round(logic [127:0] n, logic [127:0] d);
		return ((n << 1) + d) / (d << 1);
	endfunction

	function automatic result_t predict_matrix(element_t el, logic signed [T_W-1:0] amb);
		logic [127:0] coef [3];
		logic [127:0] wgt [3][3];
		logic signed [127:0] diff [3];
		logic signed [127:0] amb_w;
		logic signed [127:0] acc;
		logic [127:0] area;
		logic [127:0] q;
		logic [127:0] mag;
		logic [6:0] c;
		logic [H_W-1:0] ent [3][3];
		logic signed [T_W-1:0] ld [3];
		result_t r;
		coef[0] = 128'(el.coeff_node_a);
		coef[1] = 128'(el.coeff_node_b);
		coef[2] = 128'(el.coeff_node_c);
		area = 128'(el.face_area);
		amb_w = 128'(amb);
		diff[0] = 128'(el.temp_node_a);
		diff[1] = 128'(el.temp_node_b);
		diff[2] = 128'(el.temp_node_c);
		for (int i = 0; i < 3; i++)
			diff[i] = diff[i] - amb_w;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				wgt[i][j] = '0;
				for (int k = 0; k < 3; k++) begin
					if (i == j)
						c = (k == i) ? W_OWN : W_NEAR;
					else
						c = (k == i || k == j) ? W_NEAR : W_FAR;
					wgt[i][j] = wgt[i][j] + 128'(c) * coef[k];
				end
				q = div_round(area * wgt[i][j], ENTRY_DIV);
				ent[i][j] = (q > 128'(ENTRY_MAX)) ? ENTRY_MAX : q[H_W-1:0];
			end
		end
		// load = -M * (T - ambient), sign handled apart from the rounding
		for (int i = 0; i < 3; i++) begin
			acc = '0;
			for (int j = 0; j < 3; j++)
				acc = acc + $signed(wgt[i][j]) * diff[j];
			acc = acc * $signed(area);
			if (acc < 0) begin
				mag = -acc;
				q = div_round(mag, LOAD_DIV);
				ld[i] = (q > 128'(LOAD_MAX)) ? LOAD_MAX : q[T_W-1:0];
			end else begin
				q = div_round(acc, LOAD_DIV);
				if (q > 128'h8000_0000)
					q = 128'h8000_0000;
				ld[i] = -q[T_W-1:0];
			end
		end
		r.entry_aa = ent[0][0];
		r.entry_ab = ent[0][1];
		r.entry_ac = ent[0][2];
		r.entry_bb = ent[1][1];
		r.entry_bc = ent[1][2];
		r.entry_cc = ent[2][2];
		r.load_a = ld[0];
		r.load_b = ld[1];
		r.load_c = ld[2];
		return r;
	endfunction

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch: %s", msg);
	endtask

	task automatic check_word(result_t got, result_t want);
		logic [31:0] g [9];
		logic [31:0] w [9];
		string names [9];
		names = '{"entry_aa", "entry_ab", "entry_ac", "entry_bb", "entry_bc", "entry_cc",
			"load_a", "load_b", "load_c"};
		g = '{32'(got.entry_aa), 32'(got.entry_ab), 32'(got.entry_ac), 32'(got.entry_bb),
			32'(got.entry_bc), 32'(got.entry_cc), got.load_a, got.load_b, got.load_c};
		w = '{32'(want.entry_aa), 32'(want.entry_ab), 32'(want.entry_ac),
			32'(want.entry_bb), 32'(want.entry_bc), 32'(want.entry_cc),
			want.load_a, want.load_b, want.load_c};
		for (int f = 0; f < 9; f++)
			if (g[f] !== w[f])
				note_failure($sformatf("%s expected %h got %h", names[f], w[f], g[f]));
	endtask

	// idle cycles before the next word, with runs of back-to-back words
	function automatic int draw_wait(inout bit burst);
		if ($urandom_range(0, 39) == 0)
			burst = !burst;
		return burst ? 0 : $urandom_range(0, 6);
	endfunction

	// element driver
	always @(posedge clk) begin : drive_elements
		logic keep;
		if (arst_n) begin
			keep = elem_ch.valid;
			if (elem_ch.valid && elem_ch.ready) begin
				awaited_results.push_back(predict_matrix(elem_ch.data, ambient));
				keep = 1'b0;
				gap_left = draw_wait(src_burst);
			end
			if (!keep) begin
				if (gap_left > 0)
					gap_left--;
				else if (pending_elements.size() > 0) begin
					elem_ch.data <= pending_elements.pop_front();
					keep = 1'b1;
				end
			end
			elem_ch.valid <= keep;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (awaited_results.size() == 0)
					note_failure("result word with nothing expected");
				else
					check_word(result_ch.data, awaited_results.pop_front());
				stall_left = draw_wait(snk_burst);
			end
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((elem_ch.valid && elem_ch.ready) || (result_ch.valid && result_ch.ready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic add_element(int ha, int hb, int hc, int ta, int tb, int tc, int area);
		element_t el;
		el.coeff_node_a = H_W'(ha);
		el.coeff_node_b = H_W'(hb);
		el.coeff_node_c = H_W'(hc);
		el.temp_node_a = ta;
		el.temp_node_b = tb;
		el.temp_node_c = tc;
		el.face_area = H_W'(area);
		pending_elements.push_back(el);
	endtask

	function automatic logic [31:0] rand_field(int width, bit may_negate);
		logic [31:0] v;
		int k;
		k = $urandom_range(1, width);
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			2, 3: v = $urandom;
			default: v = $urandom >> (32 - k);
		endcase
		if (may_negate && $urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	task automatic add_random(int count);
		logic [31:0] f [7];
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 1)) begin
				// physically sized element near the ambient temperature
				for (int i = 0; i < 3; i++) begin
					f[i] = $urandom_range(ONE / 4, 200 * ONE);
					f[3 + i] = ambient + $urandom_range(0, 600 * ONE) - 300 * ONE;
				end
				f[6] = $urandom_range(ONE / 100, 4 * ONE);
			end else begin
				for (int i = 0; i < 3; i++) begin
					f[i] = rand_field(H_W, 1'b0);
					f[3 + i] = rand_field(T_W, 1'b1);
				end
				f[6] = rand_field(H_W, 1'b0);
			end
			add_element(f[0], f[1], f[2], f[3], f[4], f[5], f[6]);
		end
	endtask

	task automatic set_ambient(logic signed [T_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		ambient = v;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_elements.size() != 0 || elem_ch.valid || awaited_results.size() != 0);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		elem_ch.valid = 1'b0;
		elem_ch.data = '0;
		result_ch.ready = 1'b0;
		ambient = '0;
		fail_count = 0;
		gap_left = 0;
		stall_left = 0;
		quiet_cycles = 0;
		src_burst = 1'b0;
		snk_burst = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		set_ambient('0);
		add_element(0, 0, 0, 0, 0, 0, 0);
		add_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		// zero area, then zero coefficients
		add_element(5 * ONE, 7 * ONE, 9 * ONE, 3 * ONE, -ONE, 40 * ONE, 0);
		add_element(0, 0, 0, 100 * ONE, -100 * ONE, 5 * ONE, ONE);
		// one node's coefficient at a time
		add_element(ONE, 0, 0, ONE, 2 * ONE, 3 * ONE, ONE);
		add_element(0, ONE, 0, ONE, 2 * ONE, 3 * ONE, ONE);
		add_element(0, 0, ONE, ONE, 2 * ONE, 3 * ONE, ONE);
		add_element(ONE, ONE, ONE, ONE, -ONE, 0, ONE);
		add_element(10 * ONE, 10 * ONE, 10 * ONE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 2 * ONE);
		add_element(1, 1, 1, 1, -1, 1, 1);
		// entry_aa lands exactly on a half
		add_element(1, 0, 0, -ONE, ONE, 3, 3538944);
		add_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, ONE, -ONE, 7, 1);
		add_element(1, 1, 1, 32'h8000_0000, 32'h7FFF_FFFF, -5, 32'h7FFF_FFFF);
		// temperatures at ambient: matrix only, loads zero
		add_element(7 * ONE, 3 * ONE, 11 * ONE, 0, 0, 0, 3 * ONE);
		add_element(32'h5555_5555, 32'h2AAA_AAAA, 32'h7FFF_FFFF,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'h2AAA_AAAA);
		add_random(60);
		wait_idle();

		set_ambient(20 * ONE);
		add_random(80);
		wait_idle();

		set_ambient(-(37 * ONE + ONE / 2));
		add_random(80);
		wait_idle();

		// largest differences, no wrap expected
		set_ambient(32'h8000_0000);
		add_element(ONE, ONE, ONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, ONE);
		add_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF);
		add_random(75);
		wait_idle();

		set_ambient(32'h7FFF_FFFF);
		add_element(ONE, ONE, ONE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, ONE);
		add_element(1, 2, 3, 32'h8000_0000, 32'h7FFF_FFFF, -ONE, ONE / 8);
		add_random(75);
		wait_idle();

		set_ambient($urandom);
		add_random(80);
		wait_idle();

		set_ambient('0);
		add_random(40);
		wait_idle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && awaited_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

// ----- convective_boundary_triangle_matrix.f -----
+incdir+sv
sv/cbtm_pkg.sv
sv/cbtm_stream_if.sv
sv/cbtm_rdiv.sv
sv/cbtm_lane.sv
sv/convective_boundary_triangle_matrix.sv
sv/cbtm_checker.sv
tb/tb_top.sv
